[src/ald_pkg.sv]
// shared types, constants and helpers of the adjacent line dedup core
package ald_pkg;

  localparam int LineBytes = 2048;
  localparam int KeyAddrW  = $clog2(LineBytes);
  localparam int KeyPosW   = $clog2(LineBytes + 1);

  localparam int ByteW     = 8;
  localparam int FieldsW   = 8;
  localparam int CharsW    = 12;
  localparam int CountW    = 16;
  localparam int CfgDataW  = 12;
  localparam int CfgIdxW   = 2;

  localparam logic [ByteW-1:0]  NlByte    = 8'd10;
  localparam logic [ByteW-1:0]  SpaceByte = 8'd32;
  localparam logic [ByteW-1:0]  TabByte   = 8'd9;
  localparam logic [CountW-1:0] CountMax  = {CountW{1'b1}};

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [CfgIdxW-1:0] CfgSkipFields = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSkipChars  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMode       = 2'd2;

  typedef enum logic [1:0] {
    ModeAll      = 2'd0,
    ModeCount    = 2'd1,
    ModeRepeated = 2'd2,
    ModeUnique   = 2'd3
  } mode_e;

  // request from the group logic to the key unit
  typedef struct packed {
    logic             take;
    logic             end_line;
    logic             flush;
    logic [ByteW-1:0] data;
  } key_cmd_t;

  // line status seen by the group logic
  typedef struct packed {
    logic differs;
    logic pending;
  } key_stat_t;

  typedef struct packed {
    logic              last;
    logic [CountW-1:0] count;
    logic              cprint;
    logic              cvalid;
    logic              starts;
  } result_t;

  function automatic logic passes(mode_e mode, logic [CountW-1:0] count);
    logic ok;
    unique case (mode)
      ModeRepeated: ok = (count > CountW'(1));
      ModeUnique:   ok = (count == CountW'(1));
      default:      ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

[src/ald_ram.sv]
// generic single-port ram, read-first, registered read
module ald_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/ald_key_unit.sv]
// key extraction, line store access and key comparison
module ald_key_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ald_pkg::FieldsW-1:0]  skip_fields_i,
  input  logic [ald_pkg::CharsW-1:0]   skip_chars_i,
  input  ald_pkg::key_cmd_t            cmd_i,
  output ald_pkg::key_stat_t           stat_o
);
  import ald_pkg::*;

  logic [FieldsW-1:0] fields_q, fields_d, fields_inc;
  logic               in_field_q, in_field_d;
  logic [CharsW-1:0]  chars_q, chars_d;
  logic [KeyPosW-1:0] key_pos_q, key_pos_d;
  logic [KeyPosW-1:0] prev_len_q, prev_len_d;
  logic               differs_q, differs_d;
  logic               pending_q, pending_d;
  logic               s1_valid_q;
  logic               s1_cmp_q;
  logic [ByteW-1:0]   s1_data_q;
  logic [ByteW-1:0]   rdata;
  logic               key_hit, go_on, blank, mismatch;

  assign blank      = (cmd_i.data == SpaceByte) || (cmd_i.data == TabByte);
  assign fields_inc = fields_q + FieldsW'(1);
  assign mismatch   = s1_valid_q && s1_cmp_q && (rdata != s1_data_q);

  always_comb begin
    fields_d   = fields_q;
    in_field_d = in_field_q;
    chars_d    = chars_q;
    key_pos_d  = key_pos_q;
    prev_len_d = prev_len_q;
    pending_d  = pending_q;
    differs_d  = differs_q | mismatch;
    key_hit    = 1'b0;
    go_on      = 1'b0;
    if (cmd_i.take) begin
      pending_d = 1'b1;
      go_on     = 1'b1;
      if (fields_q < skip_fields_i) begin
        if (!blank) begin
          in_field_d = 1'b1;
          go_on      = 1'b0;
        end else if (!in_field_q) begin
          go_on = 1'b0;
        end else begin
          in_field_d = 1'b0;
          fields_d   = fields_inc;
          if (fields_inc < skip_fields_i) begin
            go_on = 1'b0;
          end
        end
      end
      if (go_on) begin
        if (chars_q < skip_chars_i) begin
          chars_d = chars_q + CharsW'(1);
        end else if (key_pos_q < KeyPosW'(LineBytes)) begin
          key_hit   = 1'b1;
          key_pos_d = key_pos_q + KeyPosW'(1);
        end
      end
    end
    if (cmd_i.end_line) begin
      prev_len_d = key_pos_q;
      key_pos_d  = '0;
      fields_d   = '0;
      in_field_d = 1'b0;
      chars_d    = '0;
      differs_d  = 1'b0;
      pending_d  = 1'b0;
    end
    if (cmd_i.flush) begin
      prev_len_d = '0;
    end
  end

  // read old byte and write new one at the same entry in one access
  ald_ram #(
    .Width (ByteW),
    .Depth (LineBytes)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (key_hit),
    .addr_i  (key_pos_q[KeyAddrW-1:0]),
    .wdata_i (cmd_i.data),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fields_q   <= '0;
      in_field_q <= 1'b0;
      chars_q    <= '0;
      key_pos_q  <= '0;
      prev_len_q <= '0;
      differs_q  <= 1'b0;
      pending_q  <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      fields_q   <= fields_d;
      in_field_q <= in_field_d;
      chars_q    <= chars_d;
      key_pos_q  <= key_pos_d;
      prev_len_q <= prev_len_d;
      differs_q  <= differs_d;
      pending_q  <= pending_d;
      s1_valid_q <= key_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmp_q  <= (key_pos_q < prev_len_q);
    s1_data_q <= cmd_i.data;
  end

  assign stat_o.differs = differs_q | mismatch | (key_pos_q != prev_len_q);
  assign stat_o.pending = pending_q;

endmodule

[src/ald_out_fifo.sv]
// small result queue taking up to two results per cycle
module ald_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_cnt_i,
  input  ald_pkg::result_t  res0_i,
  input  ald_pkg::result_t  res1_i,
  input  logic              pop_i,
  output ald_pkg::result_t  head_o,
  output logic              valid_o,
  output logic              room_o
);
  import ald_pkg::*;

  result_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q, wr_next;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                pop;

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= FifoCntW'(FifoDepth - 2));
  assign head_o  = mem_q[rd_q];
  assign pop     = pop_i && valid_o;
  assign wr_next = wr_q + FifoPtrW'(1);
  assign cnt_d   = cnt_q + FifoCntW'(push_cnt_i) - FifoCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= res0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_next] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + FifoPtrW'(push_cnt_i);
      rd_q  <= rd_q + FifoPtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

endmodule

[src/adjacent_line_dedup_core.sv]
// top level of the adjacent line dedup core: config, grouping and result stream
// Adjacent line dedup in the uniq manner. Text comes in one byte per request on
// the slave stream (tuser high marks end of input, the byte is then ignored).
// Each line's key skips skip_fields blank-led fields and then skip_chars bytes,
// and is compared byte by byte with the previous key kept in a 2048 x 8 line
// store; key bytes beyond 2048 are neither stored nor compared. Every newline
// gives one result saying whether the line starts a new group and, if a group
// closed, its count (saturating at 65535) and the print decision for the mode.
// End of input ends an unterminated line and flushes the open group, giving up
// to two results; tlast marks the last result of a request. Throughput is one
// byte per cycle: each key byte does a single read-first access to the line
// store, with the compare in the next cycle folded into the line status before
// the next newline is judged. Results go through a four-entry queue; tready
// stays high while the queue holds two results or fewer, so a byte is taken
// every cycle as long as the downstream keeps pace. The line store needs no
// clearing after reset: only entries below the previous key length are read.
module adjacent_line_dedup_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [ald_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ald_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // text input
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,  // text_byte
  input  logic                           s_axis_tuser_i,  // end_of_input
  // result output
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // starts_group, closed_valid, closed_print, closed_count[15:0], zero pad
  output logic [23:0]                    m_axis_tdata_o,
  output logic                           m_axis_tlast_o   // last_of_run
);
  import ald_pkg::*;

  logic [FieldsW-1:0] skip_fields_q;
  logic [CharsW-1:0]  skip_chars_q;
  mode_e              mode_q;
  logic               group_open_q, group_open_d;
  logic [CountW-1:0]  group_size_q, group_size_d;

  logic               req, eoi, newline, eol, flush;
  logic [CountW-1:0]  size_after_eol, size_now;
  key_cmd_t           key_cmd;
  key_stat_t          key_stat;
  result_t            eol_res, flush_res, res0, res1, head;
  logic [1:0]         push_cnt;
  logic               room;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_fields_q <= '0;
      skip_chars_q  <= '0;
      mode_q        <= ModeAll;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgSkipFields: skip_fields_q <= cfg_wdata_i[FieldsW-1:0];
        CfgSkipChars:  skip_chars_q  <= cfg_wdata_i[CharsW-1:0];
        CfgMode:       mode_q        <= mode_e'(cfg_wdata_i[1:0]);
        default:       ;
      endcase
    end
  end

  assign s_axis_tready_o = room;
  assign req     = s_axis_tvalid_i && room;
  assign eoi     = s_axis_tuser_i;
  assign newline = req && !eoi && (s_axis_tdata_i == NlByte);
  // a line ends on newline, or on end of input with a line still pending
  assign eol     = newline || (req && eoi && key_stat.pending);
  assign flush   = req && eoi && (eol || group_open_q);

  assign key_cmd.take     = req && !eoi && (s_axis_tdata_i != NlByte);
  assign key_cmd.end_line = eol;
  assign key_cmd.flush    = flush;
  assign key_cmd.data     = s_axis_tdata_i;

  ald_key_unit u_key (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .skip_fields_i (skip_fields_q),
    .skip_chars_i  (skip_chars_q),
    .cmd_i         (key_cmd),
    .stat_o        (key_stat)
  );

  // group bookkeeping for the line being ended
  always_comb begin
    eol_res = '0;
    if (!group_open_q) begin
      eol_res.starts = 1'b1;
      size_after_eol = CountW'(1);
    end else if (key_stat.differs) begin
      eol_res.starts = 1'b1;
      eol_res.cvalid = 1'b1;
      eol_res.cprint = passes(mode_q, group_size_q);
      eol_res.count  = group_size_q;
      size_after_eol = CountW'(1);
    end else if (group_size_q != CountMax) begin
      size_after_eol = group_size_q + CountW'(1);
    end else begin
      size_after_eol = group_size_q;
    end
  end

  // flush closes whatever group is open once the pending line is counted
  assign size_now = eol ? size_after_eol : group_size_q;

  always_comb begin
    flush_res        = '0;
    flush_res.cvalid = 1'b1;
    flush_res.cprint = passes(mode_q, size_now);
    flush_res.count  = size_now;
    flush_res.last   = 1'b1;
  end

  always_comb begin
    res0      = eol ? eol_res : flush_res;
    res0.last = !(eol && flush);
    res1      = flush_res;
    push_cnt  = {1'b0, eol} + {1'b0, flush};
  end

  always_comb begin
    group_open_d = group_open_q;
    group_size_d = group_size_q;
    if (flush) begin
      group_open_d = 1'b0;
      group_size_d = '0;
    end else if (eol) begin
      group_open_d = 1'b1;
      group_size_d = size_after_eol;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_open_q <= 1'b0;
      group_size_q <= '0;
    end else begin
      group_open_q <= group_open_d;
      group_size_q <= group_size_d;
    end
  end

  ald_out_fifo u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .res0_i     (res0),
    .res1_i     (res1),
    .pop_i      (m_axis_tready_i),
    .head_o     (head),
    .valid_o    (m_axis_tvalid_o),
    .room_o     (room)
  );

  assign m_axis_tdata_o = {5'd0, head.count, head.cprint, head.cvalid, head.starts};
  assign m_axis_tlast_o = head.last;

  // an open group always holds at least one line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    group_open_q == (group_size_q != '0))
    else $error("group open flag and size disagree");

  // end of input always leaves no group open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req && eoi) |=> !group_open_q)
    else $error("group still open after end of input");

  // a newline always leaves a group open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    newline |=> group_open_q)
    else $error("no group open after a line end");

  // a print decision only comes with a closed group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (head.cvalid || (!head.cprint && head.count == '0)))
    else $error("print or count without a closed group");

endmodule

[test/tb_top.sv]
// testbench of the adjacent line dedup core: byte stream stimulus, grouping predictor and checker
module tb_top;
  import ald_pkg::*;

  // one text request: a byte or an end-of-input marker
  typedef struct packed {
    logic             eoi;
    logic [ByteW-1:0] text;
  } text_req_t;

  // one group report as the core should give it
  typedef struct packed {
    logic              starts;
    logic              cvalid;
    logic              cprint;
    logic [CountW-1:0] count;
    logic              last;
  } group_report_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i = '0;
  logic                s_axis_tuser_i = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [23:0]         m_axis_tdata_o;
  logic                m_axis_tlast_o;

  adjacent_line_dedup_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #6 clk_i = ~clk_i;

  // stimulus and expectation stores
  text_req_t     pending_text [$];
  group_report_t expected_reports [$];
  int            error_count = 0;
  int            queued_items = 0;

  // handshake bookkeeping and idling knobs
  logic        text_req_taken = 1'b0;
  logic        report_taken = 1'b0;
  int unsigned text_gap = 0;
  int unsigned report_stall = 0;
  int unsigned text_idle_max = 3;
  int unsigned report_idle_max = 3;

  mode_e random_modes [4] = '{ModeAll, ModeCount, ModeRepeated, ModeUnique};

  // predictor state, the line store holds the previous key
  logic [ByteW-1:0]   prev_line [LineBytes];
  logic [KeyPosW-1:0] prev_len = '0;
  logic [KeyPosW-1:0] key_pos = '0;
  logic [FieldsW-1:0] fields_done = '0;
  logic               in_field = 1'b0;
  logic [CharsW-1:0]  chars_done = '0;
  logic               line_differs = 1'b0;
  logic               line_open = 1'b0;
  logic               group_open = 1'b0;
  logic [CountW-1:0]  group_size = '0;
  logic [FieldsW-1:0] skip_fields_cfg = '0;
  logic [CharsW-1:0]  skip_chars_cfg = '0;
  mode_e              dedup_mode = ModeAll;

  function automatic logic group_printed(logic [CountW-1:0] n);
    if (dedup_mode == ModeRepeated) return n > CountW'(1);
    if (dedup_mode == ModeUnique) return n == CountW'(1);
    return 1'b1;
  endfunction

  // skip blank-led fields, then skip_chars bytes, then compare and store the key
  function automatic void take_text_byte(logic [ByteW-1:0] b);
    logic blank;
    blank = (b == SpaceByte) || (b == TabByte);
    line_open = 1'b1;
    if (fields_done < skip_fields_cfg) begin
      if (!blank) begin
        in_field = 1'b1;
        return;
      end
      if (!in_field) return;
      in_field = 1'b0;
      fields_done++;
      if (fields_done < skip_fields_cfg) return;
    end
    if (chars_done < skip_chars_cfg) begin
      chars_done++;
      return;
    end
    if (key_pos >= LineBytes) return;
    if (key_pos >= prev_len || prev_line[key_pos] != b) line_differs = 1'b1;
    prev_line[key_pos] = b;
    key_pos++;
  endfunction

  function automatic group_report_t close_line();
    group_report_t r;
    r = '0;
    if (!group_open) begin
      r.starts = 1'b1;
      group_open = 1'b1;
      group_size = CountW'(1);
    end else if (line_differs || key_pos != prev_len) begin
      r.starts = 1'b1;
      r.cvalid = 1'b1;
      r.cprint = group_printed(group_size);
      r.count = group_size;
      group_size = CountW'(1);
    end else if (group_size != CountMax) begin
      group_size++;
    end
    prev_len = key_pos;
    key_pos = '0;
    fields_done = '0;
    in_field = 1'b0;
    chars_done = '0;
    line_differs = 1'b0;
    line_open = 1'b0;
    return r;
  endfunction

  function automatic void predict_request(logic [ByteW-1:0] b, logic eoi);
    group_report_t outs [2];
    group_report_t r;
    int n;
    n = 0;
    if (!eoi) begin
      if (b == NlByte) begin
        outs[0] = close_line();
        n = 1;
      end else begin
        take_text_byte(b);
      end
    end else begin
      // an unterminated line ends first, then the open group is flushed
      if (line_open) begin
        outs[0] = close_line();
        n = 1;
      end
      if (group_open) begin
        r = '0;
        r.cvalid = 1'b1;
        r.cprint = group_printed(group_size);
        r.count = group_size;
        outs[n] = r;
        n++;
        group_open = 1'b0;
        group_size = '0;
        prev_len = '0;
      end
    end
    for (int i = 0; i < n; i++) begin
      r = outs[i];
      r.last = (i == n - 1);
      expected_reports.push_back(r);
    end
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, what, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_report(logic [23:0] data, logic last);
    group_report_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t unexpected result: expected none, actual data %h last %b",
               $time, data, last);
      error_count++;
      return;
    end
    want = expected_reports.pop_front();
    check_field("starts_group", want.starts, data[0]);
    check_field("closed_valid", want.cvalid, data[1]);
    check_field("closed_print", want.cprint, data[2]);
    check_field("closed_count", want.count, data[18:3]);
    check_field("last_of_run", want.last, last);
  endfunction

  // monitor: predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    text_req_taken <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    report_taken <= rst_ni && m_axis_tvalid_o && m_axis_tready_i;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) predict_request(s_axis_tdata_i, s_axis_tuser_i);
      if (m_axis_tvalid_o && m_axis_tready_i) check_report(m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  // driver: next request after the drawn gap, valid held until taken
  always @(negedge clk_i) begin : drive_text
    text_req_t req;
    if (rst_ni && (!s_axis_tvalid_i || text_req_taken)) begin
      if (text_gap != 0 || pending_text.size() == 0) begin
        s_axis_tvalid_i <= 1'b0;
        if (text_gap != 0) text_gap <= text_gap - 1;
      end else begin
        req = pending_text.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= req.text;
        s_axis_tuser_i <= req.eoi;
        text_gap <= $urandom_range(text_idle_max, 0);
      end
    end
  end

  // receiver: a stall drawn after every result taken
  always @(negedge clk_i) begin : drive_ready
    int unsigned hold;
    if (rst_ni) begin
      if (report_taken) begin
        hold = $urandom_range(report_idle_max, 0);
        if (hold != 0) begin
          m_axis_tready_i <= 1'b0;
          report_stall <= hold - 1;
        end else begin
          m_axis_tready_i <= 1'b1;
        end
      end else if (report_stall != 0) begin
        m_axis_tready_i <= 1'b0;
        report_stall <= report_stall - 1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  function automatic void send_byte(logic [ByteW-1:0] b);
    text_req_t req;
    req.eoi = 1'b0;
    req.text = b;
    pending_text.push_back(req);
    queued_items++;
  endfunction

  // the byte beside an end-of-input marker is random, it must be ignored
  function automatic void send_end();
    text_req_t req;
    req.eoi = 1'b1;
    req.text = ByteW'($urandom_range(255, 0));
    pending_text.push_back(req);
    queued_items++;
  endfunction

  function automatic void send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endfunction

  function automatic logic [ByteW-1:0] blank_byte();
    return ($urandom_range(1, 0) != 0) ? SpaceByte : TabByte;
  endfunction

  function automatic logic [ByteW-1:0] word_byte();
    logic [ByteW-1:0] b;
    do b = ByteW'($urandom_range(255, 0));
    while (b == NlByte || b == SpaceByte || b == TabByte);
    return b;
  endfunction

  // any byte but newline, with blanks frequent enough to matter
  function automatic logic [ByteW-1:0] any_text_byte();
    logic [ByteW-1:0] b;
    if ($urandom_range(3, 0) == 0) return blank_byte();
    do b = ByteW'($urandom_range(255, 0));
    while (b == NlByte);
    return b;
  endfunction

  // a line whose skipped prefix is fresh random matter and whose key is given
  function automatic void send_line(logic [ByteW-1:0] key [$], bit with_nl);
    int nf;
    int nc;
    nf = (skip_fields_cfg <= 3) ? int'(skip_fields_cfg) : 0;
    nc = (skip_chars_cfg <= 4) ? int'(skip_chars_cfg) : 0;
    for (int f = 0; f < nf; f++) begin
      if ($urandom_range(1, 0) != 0) send_byte(blank_byte());
      repeat ($urandom_range(3, 1)) send_byte(word_byte());
      send_byte(SpaceByte);
    end
    repeat (nc) send_byte(any_text_byte());
    foreach (key[i]) send_byte(key[i]);
    if (with_nl) send_byte(NlByte);
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= CfgDataW'(value);
    case (idx)
      CfgSkipFields: skip_fields_cfg = FieldsW'(value);
      CfgSkipChars:  skip_chars_cfg = CharsW'(value);
      CfgMode:       dedup_mode = mode_e'(value[1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input int unsigned sf, input int unsigned sc, input mode_e m);
    write_reg(CfgSkipFields, sf);
    write_reg(CfgSkipChars, sc);
    write_reg(CfgMode, m);
  endtask

  // sender holds off until every request is taken and every result is back
  task automatic finish_phase(input int settle);
    int waited;
    // sampled at the rising edge, where the driver never changes the queue or valid
    while (pending_text.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    @(negedge clk_i);
    waited = 0;
    while (expected_reports.size() != 0 && waited < 4000) begin
      @(negedge clk_i);
      waited++;
    end
    if (expected_reports.size() != 0) begin
      $display("%0t missing results: expected %0d more, actual none",
               $time, expected_reports.size());
      error_count++;
      expected_reports.delete();
    end
    repeat (settle) @(negedge clk_i);
  endtask

  // groups of repeated keys with random prefixes, some near misses, noise and
  // stray end markers in between
  task automatic random_phase(input int target);
    logic [ByteW-1:0] key [$];
    int reps;
    bit tail_open;
    queued_items = 0;
    while (queued_items < target) begin
      case ($urandom_range(9, 0))
        0: repeat ($urandom_range(8, 1)) send_byte(ByteW'($urandom_range(255, 0)));
        1: begin
          send_end();
          if ($urandom_range(1, 0) != 0) send_end();
        end
        default: begin
          key.delete();
          repeat ($urandom_range(5, 0)) key.push_back(any_text_byte());
          reps = $urandom_range(4, 1);
          tail_open = ($urandom_range(9, 0) == 0);
          for (int r = 0; r < reps; r++) begin
            if (r != 0 && $urandom_range(4, 0) == 0) key.push_back(any_text_byte());
            send_line(key, !(tail_open && r == reps - 1));
          end
          if (tail_open) send_end();
        end
      endcase
    end
    send_end();
    finish_phase(8);
  endtask

  initial begin
    int unsigned sf;
    int unsigned sc;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // plain keys: end with nothing open, open, continue, close, zero and 0xff
    // bytes, an unterminated line flushed by end of input, a second end
    set_config(0, 0, ModeAll);
    send_end();
    send_text("a\na\n\n");
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(NlByte);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(NlByte);
    send_text("ab");
    send_end();
    send_end();
    finish_phase(8);

    // one blank-led field and one byte skipped, repeated groups only
    set_config(1, 1, ModeRepeated);
    send_text(" a xk\nb\tyk\n");
    send_end();
    finish_phase(8);

    // widest skips leave every key empty, unique groups only
    set_config(255, 4095, ModeUnique);
    send_text("p q\nr\n");
    send_end();
    finish_phase(8);

    for (int p = 0; p < 4; p++) begin
      text_idle_max = (p == 1) ? 0 : 3;
      report_idle_max = (p == 1 || p == 3) ? 0 : 3;
      case ($urandom_range(3, 0))
        0: sf = 0;
        1: sf = 1;
        2: sf = 2;
        default: sf = $urandom_range(255, 0);
      endcase
      case ($urandom_range(3, 0))
        0: sc = 0;
        1: sc = 1;
        2: sc = 3;
        default: sc = $urandom_range(4095, 0);
      endcase
      set_config(sf, sc, random_modes[p]);
      random_phase(100);
    end

    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
